>>> src/ksf_pkg.sv
package ksf_pkg;

    localparam int MAX_ORDER   = 64;
    localparam int INDEX_BITS  = 16;
    localparam int VALUE_BITS  = 64;
    localparam int ORDER_BITS  = 7;
    localparam int POS_BITS    = $clog2(MAX_ORDER);
    localparam int KEFF_BITS   = $clog2(MAX_ORDER + 1);
    localparam int SEED_COUNT  = 3;

    localparam logic [ORDER_BITS-1:0] ORDER_RESET = ORDER_BITS'(2);
    localparam logic [VALUE_BITS-1:0] VALUE_MAX   = {VALUE_BITS{1'b1}};

    typedef struct packed {
        logic                  start;
        logic [INDEX_BITS-1:0] target;
        logic [ORDER_BITS-1:0] order;
        logic                  res_ready;
    } walk_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [VALUE_BITS-1:0] value;
        logic                  over;
    } walk_rsp_t;

    // Order zero behaves as one, anything above the ring depth as the depth.
    function automatic logic [KEFF_BITS-1:0] eff_order(input logic [ORDER_BITS-1:0] ord);
        logic [KEFF_BITS-1:0] k;
        if (ord == '0)
            k = KEFF_BITS'(1);
        else if (32'(ord) > MAX_ORDER)
            k = KEFF_BITS'(MAX_ORDER);
        else
            k = KEFF_BITS'(ord);
        return k;
    endfunction

endpackage

>>> src/ksf_walk.sv
module ksf_walk (
    input  logic              clk,
    input  logic              rst_n,
    input  ksf_pkg::walk_req_t req,
    output ksf_pkg::walk_rsp_t rsp
);
    import ksf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t                 state_reg, state_next;
    logic [INDEX_BITS-1:0]  step_reg, step_next;
    logic [INDEX_BITS-1:0]  target_reg, target_next;
    logic [KEFF_BITS-1:0]   k_reg, k_next;
    logic [VALUE_BITS-1:0]  window_reg, window_next;
    logic [POS_BITS-1:0]    pos_reg, pos_next;
    logic                   sat_reg, sat_next;
    logic                   fwd_reg, fwd_next;
    logic [VALUE_BITS-1:0]  fwd_val_reg;

    logic [VALUE_BITS-1:0]  ring_mem [MAX_ORDER];
    logic [VALUE_BITS-1:0]  rd_data_reg;
    logic                   rd_en;
    logic [POS_BITS-1:0]    rd_addr;
    logic                   wr_en;

    logic [VALUE_BITS-1:0]  term;
    logic [VALUE_BITS-1:0]  oldest;
    logic [VALUE_BITS-1:0]  rest;
    logic [VALUE_BITS:0]    sum;
    logic                   ovf_hit;
    logic                   finish;
    logic [KEFF_BITS-1:0]   pos_inc;
    logic [POS_BITS-1:0]    pos_adv;

    always_comb
    begin
        if (step_reg == '0)
            term = '0;
        else if (step_reg < INDEX_BITS'(SEED_COUNT))
            term = VALUE_BITS'(1);
        else
            term = window_reg;

        ovf_hit = (step_reg >= INDEX_BITS'(SEED_COUNT)) && sat_reg;
        finish  = ovf_hit || (step_reg == target_reg);

        oldest  = fwd_reg ? fwd_val_reg : rd_data_reg;
        if (step_reg >= INDEX_BITS'(k_reg))
            rest = window_reg - oldest;
        else
            rest = window_reg;
        sum = {1'b0, rest} + {1'b0, term};

        pos_inc = KEFF_BITS'(pos_reg) + KEFF_BITS'(1);
        pos_adv = (pos_inc >= k_reg) ? '0 : POS_BITS'(pos_inc);
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        target_next = target_reg;
        k_next      = k_reg;
        window_next = window_reg;
        pos_next    = pos_reg;
        sat_next    = sat_reg;
        fwd_next    = fwd_reg;
        rd_en       = 1'b0;
        rd_addr     = pos_adv;
        wr_en       = 1'b0;
        rsp.busy    = (state_reg != ST_IDLE);
        rsp.done    = 1'b0;
        rsp.value   = ovf_hit ? VALUE_MAX : term;
        rsp.over    = ovf_hit;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.start)
                begin
                    state_next  = ST_WALK;
                    step_next   = '0;
                    target_next = req.target;
                    k_next      = eff_order(req.order);
                    window_next = '0;
                    pos_next    = '0;
                    sat_next    = 1'b0;
                    fwd_next    = 1'b0;
                    rd_en       = 1'b1;
                    rd_addr     = '0;
                end
            end
            ST_WALK:
            begin
                if (finish)
                begin
                    // hold the walk until the result register can take it
                    if (req.res_ready)
                    begin
                        rsp.done   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    wr_en     = 1'b1;
                    rd_en     = 1'b1;
                    step_next = step_reg + INDEX_BITS'(1);
                    pos_next  = pos_adv;
                    // a ring of one reads back the entry written this cycle
                    fwd_next  = (pos_adv == pos_reg);
                    if (sum[VALUE_BITS])
                    begin
                        window_next = VALUE_MAX;
                        sat_next    = 1'b1;
                    end
                    else
                    begin
                        window_next = sum[VALUE_BITS-1:0];
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            target_reg <= '0;
            k_reg      <= KEFF_BITS'(1);
            window_reg <= '0;
            pos_reg    <= '0;
            sat_reg    <= 1'b0;
            fwd_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            target_reg <= target_next;
            k_reg      <= k_next;
            window_reg <= window_next;
            pos_reg    <= pos_next;
            sat_reg    <= sat_next;
            fwd_reg    <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            fwd_val_reg <= term;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            ring_mem[pos_reg] <= term;
        if (rd_en)
            rd_data_reg <= ring_mem[rd_addr];
    end

endmodule

>>> src/k_step_fibonacci_term.sv
// Channel   Signals                                   Transfer when
// in        in_valid, in_stall, term_index            in_valid && !in_stall
// out       out_valid, out_stall, term_value,         out_valid && !out_stall
//           overflowed
// cfg       cfg_valid, cfg_ready, cfg_data (order)    cfg_valid && cfg_ready
//
// A request walks one term per cycle through the ring memory and ends early
// once the sum leaves 64 bits; the next request is taken only after the walk
// has returned to idle. The read of the ring memory is overlapped with the
// write of the current term.
// Reset clears the walk state and sets the order to 2; the ring needs no clearing.
// A stalled result holds in the output register; a new request may still start.
module k_step_fibonacci_term (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [ksf_pkg::INDEX_BITS-1:0]   term_index,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ksf_pkg::VALUE_BITS-1:0]   term_value,
    output logic                             overflowed,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ksf_pkg::ORDER_BITS-1:0]   cfg_data
);
    import ksf_pkg::*;

    logic [ORDER_BITS-1:0] order_reg;
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  over_reg;
    walk_req_t             req;
    walk_rsp_t             rsp;

    assign cfg_ready = 1'b1;

    assign req.start     = in_valid && !in_stall;
    assign req.target    = term_index;
    assign req.order     = order_reg;
    assign req.res_ready = !out_valid_reg || !out_stall;

    assign in_stall   = rsp.busy;
    assign out_valid  = out_valid_reg;
    assign term_value = value_reg;
    assign overflowed = over_reg;

    ksf_walk u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg     <= ORDER_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                order_reg <= cfg_data;
            if (rsp.done)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp.done)
        begin
            value_reg <= rsp.value;
            over_reg  <= rsp.over;
        end
    end

endmodule

>>> src/ksf_checker.sv
module ksf_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [ksf_pkg::VALUE_BITS-1:0]   term_value,
    input logic                             overflowed
);
    import ksf_pkg::*;

    // an overflowed term reads as all ones
    a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflowed |-> term_value == VALUE_MAX)
        else $error("overflowed result not saturated");

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(term_value) && $stable(overflowed))
        else $error("stalled result changed");

    // a transfer in starts a walk, so the input stalls next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after request transfer");

    // a result only appears at the end of a walk
    a_result_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a walk");

endmodule

bind k_step_fibonacci_term ksf_checker u_ksf_checker (.*);

>>> bench/ksf_term_checker.sv
`timescale 1ns / 1ps

module ksf_term_checker
    import ksf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [INDEX_BITS-1:0] term_index,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [VALUE_BITS-1:0] term_value,
    input  logic                  overflowed,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [ORDER_BITS-1:0] cfg_data,
    output int                    errors,
    output int                    pending,
    output int                    checked,
    output int                    saturations
);

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  over;
    } term_t;

    localparam int REPORT_LIMIT = 10;

    logic [ORDER_BITS-1:0] order_shadow;
    term_t                 term_queue[$];
    term_t                 got;
    term_t                 want;
    int                    fail_count;
    int                    good_count;
    int                    sat_count;

    // Walk the sequence from term 0, keeping the last k terms and their sum.
    function automatic term_t kbonacci_term(input logic [INDEX_BITS-1:0] target,
                                            input logic [ORDER_BITS-1:0] ord);
        logic [VALUE_BITS-1:0] ring [MAX_ORDER];
        logic [VALUE_BITS-1:0] total;
        logic [VALUE_BITS-1:0] rest;
        logic [VALUE_BITS-1:0] t;
        int unsigned           span;
        int unsigned           pos;
        int unsigned           n;
        logic                  sat;
        term_t                 r;
        if (ord == '0)
            span = 1;
        else if (int'(ord) > MAX_ORDER)
            span = MAX_ORDER;
        else
            span = ord;
        total = '0;
        pos   = 0;
        sat   = 1'b0;
        r     = '0;
        for (n = 0; n <= target; n++)
        begin
            if (n == 0)
                t = '0;
            else if (n < SEED_COUNT)
                t = 1;
            else if (sat)
            begin
                // every later term is at least as large: stop at the first one out of range
                r.value = VALUE_MAX;
                r.over  = 1'b1;
                break;
            end
            else
                t = total;
            if (n == target)
            begin
                r.value = t;
                r.over  = 1'b0;
                break;
            end
            rest = total;
            if (n >= span)
                rest = rest - ring[pos];
            ring[pos] = t;
            if (t > VALUE_MAX - rest)
            begin
                sat   = 1'b1;
                total = VALUE_MAX;
            end
            else
                total = rest + t;
            pos++;
            if (pos >= span)
                pos = 0;
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input term_t exp_t, input term_t act_t);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%t ksf_term_checker: %s: expected value %h over %b, got value %h over %b",
                     $realtime, what, exp_t.value, exp_t.over, act_t.value, act_t.over);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_shadow <= ORDER_RESET;
            term_queue.delete();
            fail_count   = 0;
            good_count   = 0;
            sat_count    = 0;
            errors       <= 0;
            pending      <= 0;
            checked      <= 0;
            saturations  <= 0;
        end
        else
        begin
            // retire the result first so a same-edge request cannot be matched to it
            if (out_valid && !out_stall)
            begin
                got.value = term_value;
                got.over  = overflowed;
                if (term_queue.size() == 0)
                    flag_mismatch("result with no request waiting", '0, got);
                else
                begin
                    want = term_queue.pop_front();
                    if (got !== want)
                        flag_mismatch("term mismatch", want, got);
                    else
                    begin
                        good_count++;
                        if (got.over)
                            sat_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                term_queue.push_back(kbonacci_term(term_index, order_shadow));
            if (cfg_valid && cfg_ready)
                order_shadow <= cfg_data;
            errors      <= fail_count;
            pending     <= term_queue.size();
            checked     <= good_count;
            saturations <= sat_count;
        end
    end

endmodule

>>> bench/tb_k_step_fibonacci_term.sv
`timescale 1ns / 1ps

module tb_k_step_fibonacci_term;
    import ksf_pkg::*;

    localparam int PHASES      = 6;
    localparam int SETTLE_WAIT = 4;

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [INDEX_BITS-1:0] term_index = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [VALUE_BITS-1:0] term_value;
    logic                  overflowed;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [ORDER_BITS-1:0] cfg_data   = '0;

    int errors;
    int pending;
    int checked;
    int saturations;
    int requests_sent;
    int order_writes;
    bit calm;

    k_step_fibonacci_term dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .term_index (term_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .term_value (term_value),
        .overflowed (overflowed),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    ksf_term_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .term_index  (term_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .term_value  (term_value),
        .overflowed  (overflowed),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .pending     (pending),
        .checked     (checked),
        .saturations (saturations)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Orders zero and one never saturate, so their walk runs the full index: keep those short.
    function automatic logic [INDEX_BITS-1:0] pick_index(input logic [ORDER_BITS-1:0] ord,
                                                         input bit allow_long);
        int r;
        r = $urandom_range(0, 99);
        if (ord <= 1 && !allow_long)
            return INDEX_BITS'($urandom_range(0, 300));
        if (r < 20)
            return INDEX_BITS'($urandom_range(0, 8));
        if (r < 65)
            return INDEX_BITS'($urandom_range(0, 150));
        return INDEX_BITS'($urandom_range(0, 65535));
    endfunction

    task automatic send_index(input logic [INDEX_BITS-1:0] idx);
        int gap;
        gap = pick_gap(calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        term_index <= idx;
        do @(posedge clk); while (in_stall);
        requests_sent++;
    endtask

    // Hold off until every request has been answered and the walk has settled.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic set_order(input logic [ORDER_BITS-1:0] ord);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= ord;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        order_writes++;
    endtask

    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = pick_gap(1'b0);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4))
                @(posedge clk);
        end
    end

    initial
    begin
        logic [ORDER_BITS-1:0] ord;
        int                    count;
        int                    pause_at;
        int                    long_at;
        requests_sent = 0;
        order_writes  = 0;
        calm          = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // order two after reset: seeds, last term that fits, first that overflows
        send_index(0);
        send_index(1);
        send_index(2);
        send_index(3);
        send_index(93);
        send_index(94);
        send_index('1);
        // order zero acts as one: the walk runs to the top index
        set_order(0);
        send_index(3);
        send_index('1);
        set_order(1);
        send_index(2);
        send_index(40);
        set_order(3);
        send_index(3);
        send_index(4);
        // full window: doubling terms up to the edge of 64 bits
        set_order(ORDER_BITS'(MAX_ORDER));
        send_index(63);
        send_index(64);
        send_index(65);
        send_index(66);
        send_index(200);
        // orders past the ring depth clamp to it
        set_order(ORDER_BITS'(MAX_ORDER + 1));
        send_index(66);
        set_order('1);
        send_index(65);
        send_index(300);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: ord = 1;
                1: ord = ORDER_BITS'(MAX_ORDER);
                2: ord = '1;
                3: ord = 0;
                default: ord = ORDER_BITS'($urandom_range(0, (1 << ORDER_BITS) - 1));
            endcase
            set_order(ord);
            calm     = ($urandom_range(0, 3) == 0);
            count    = $urandom_range(11, 14);
            pause_at = $urandom_range(3, count - 2);
            long_at  = $urandom_range(0, count - 1);
            for (int j = 0; j < count; j++)
            begin
                if (j == pause_at)
                    drain();
                send_index(pick_index(ord, j == long_at));
            end
        end

        drain();
        $display("tb_k_step_fibonacci_term: %0d requests over %0d order writes, %0d results matched",
                 requests_sent, order_writes, checked);
        $display("tb_k_step_fibonacci_term: %0d of them saturated", saturations);
        if (errors == 0 && pending == 0)
            $display("tb_k_step_fibonacci_term: done, clean");
        else
            $display("tb_k_step_fibonacci_term: done, errors");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("tb_k_step_fibonacci_term: done, errors");
        $finish;
    end

endmodule

>>> sim.f
src/ksf_pkg.sv
src/ksf_walk.sv
src/k_step_fibonacci_term.sv
src/ksf_checker.sv
bench/ksf_term_checker.sv
bench/tb_k_step_fibonacci_term.sv
